FILE: rtl/core/mfps_pkg.sv
// mfps_pkg: widths, constants, register indexes and pipeline types
// for the mapping false-positive score block
// no dependencies; used by the top level and its checker
package mfps_pkg;

	// field widths
	localparam int IN_W   = 32;
	localparam int E_W    = 17;
	localparam int DB_W   = 40;
	localparam int EXT_W  = 8;
	localparam int F_W    = 16;
	localparam int FL_W   = 17;
	localparam int CFG_W  = 40;
	localparam int CIDX_W = 2;

	// fixed point
	localparam int FRAC_BITS = 15;
	localparam logic [F_W-1:0]  ONE     = F_W'(32'd1 << FRAC_BITS);
	localparam logic [FL_W-1:0] LEN_CAP = FL_W'((32'd4 << FRAC_BITS) - 32'd1);
	localparam logic [E_W-1:0]  E_ONE   = E_W'(32'd65536);
	localparam int SQ2_W = 21;
	localparam logic [SQ2_W-1:0] SQRT2_Q20 = SQ2_W'(32'd1482910);

	// log2 unit: one squaring per stage
	localparam int LOG_FRAC  = 30;
	localparam int LOG_STEPS = LOG_FRAC;
	localparam int MSB_W     = 6;
	localparam int LR_W      = MSB_W + LOG_FRAC;

	// dividers: one quotient bit per stage
	localparam int DIV_W  = 80;
	localparam int DIV_QB = 17;

	// output queue entries
	localparam int OQ_DEPTH = 2;

	// operand widths
	localparam int SPN_W = IN_W + SQ2_W;          // deviation times sqrt2
	localparam int SPD_W = E_W + IN_W + 12;       // error rate times length, scaled
	localparam int QS_W  = IN_W + 1;              // positive span
	localparam int CVN_W = IN_W + 16;             // covered count scaled
	localparam int CVD_W = QS_W + E_W;            // span times one minus error rate

	// pipeline stage positions
	localparam int ST_S1  = 0;
	localparam int ST_S2  = ST_S1 + 1;
	localparam int ST_DVP = ST_S2 + LOG_STEPS + 1;
	localparam int ST_FIN = ST_DVP + DIV_QB + 1;
	localparam int NST    = ST_FIN + 3;

	typedef enum logic [CIDX_W-1:0] {
		CFG_ERR   = 2'd0,
		CFG_DBLEN = 2'd1,
		CFG_QEXT  = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [IN_W-1:0]          cov;
		logic [IN_W-1:0]          dev;
		logic [IN_W-1:0]          len;
		logic signed [IN_W+1:0]   span;
	} s1_t;

	typedef struct packed {
		logic len_zero;
		logic e_zero;
		logic e_ge1;
		logic span_zero;
		logic span_neg;
		logic db_zero;
		logic db_one;
	} flg_t;

	typedef struct packed {
		logic [SPN_W-1:0] sp_num;
		logic [SPD_W-1:0] sp_den;
		logic [QS_W-1:0]  qs_num;
		logic [IN_W-1:0]  qs_den;
		logic [CVN_W-1:0] cv_num;
		logic [CVD_W-1:0] cv_den;
	} op_t;

	typedef struct packed {
		logic [IN_W-1:0] ml;
		logic [IN_W-1:0] md;
		logic [LR_W-1:0] rl;
		logic [LR_W-1:0] rd;
	} lg_t;

	typedef struct packed {
		op_t  op;
		lg_t  lg;
		flg_t fl;
	} mid_t;

	typedef struct packed {
		logic [DIV_W-1:0]  rem;
		logic [DIV_W-1:0]  den;
		logic [DIV_QB-1:0] quo;
		logic              ovf;
	} div_t;

	typedef struct packed {
		div_t sp;
		div_t qs;
		div_t cv;
		div_t ln;
		flg_t fl;
	} dvs_t;

	typedef struct packed {
		logic [F_W-1:0]  fs;
		logic [F_W-1:0]  fp;
		logic [F_W-1:0]  fc;
		logic [FL_W-1:0] fl;
		logic [F_W-1:0]  p;
	} fac_t;

endpackage

FILE: rtl/core/mapping_false_positive_score.sv
// mapping_false_positive_score: fully pipelined scorer for candidate read mappings
// depends on mfps_pkg (types, constants, stage positions)
//
// usage
//  - config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes error rate,
//    database length and query end extension; cfg_ready is always high and writes
//    belong between streams, while no item is in flight; an unknown index is ignored
//  - input channel (in_valid/in_ready) takes one mapping per transfer, output channel
//    (out_valid/out_ready) returns the score and its four factors per transfer
//  - an input passes 2 front stages, 30 log2 squaring stages, 1 divider setup stage,
//    17 divider bit stages, 1 factor stage and 2 score multiply stages; the last
//    multiply writes a 2-entry output queue
//  - throughput is one item per cycle while the output queue is not full, set by
//    the one-squaring and one-quotient-bit per stage layout; every stage moves on
//    one shared enable
//  - the pipeline advances while the output queue is not full, so inputs keep
//    flowing while one finished result waits for the receiver; with the queue
//    full the pipeline holds and in_ready is low, nothing is dropped or repeated
//  - reset clears config registers, stage valid bits and the queue count; no
//    clearing pass is needed
module mapping_false_positive_score (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mfps_pkg::CIDX_W-1:0]       cfg_index,
	input  logic [mfps_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [mfps_pkg::IN_W-1:0]         span_start,
	input  logic [mfps_pkg::IN_W-1:0]         span_end,
	input  logic [mfps_pkg::IN_W-1:0]         covered_count,
	input  logic [mfps_pkg::IN_W-1:0]         spread_q8,
	input  logic [mfps_pkg::IN_W-1:0]         read_len,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [mfps_pkg::F_W-1:0]          score_q15,
	output logic [mfps_pkg::F_W-1:0]          spread_factor,
	output logic [mfps_pkg::F_W-1:0]          span_factor,
	output logic [mfps_pkg::F_W-1:0]          coverage_factor,
	output logic [mfps_pkg::FL_W-1:0]         length_factor
);

	// most significant set bit, zero for zero
	function automatic logic [mfps_pkg::MSB_W-1:0] msb_pos(logic [mfps_pkg::DB_W-1:0] x);
		logic [mfps_pkg::MSB_W-1:0] r;
		r = '0;
		for (int b = 0; b < mfps_pkg::DB_W; b++) begin
			if (x[b]) r = mfps_pkg::MSB_W'(b);
		end
		return r;
	endfunction

	// mantissa in [2^31, 2^32), low bits dropped for wide values
	function automatic logic [mfps_pkg::IN_W-1:0] norm(logic [mfps_pkg::DB_W-1:0] x,
		logic [mfps_pkg::MSB_W-1:0] msb);
		logic [mfps_pkg::IN_W-1:0] r;
		if (msb <= mfps_pkg::MSB_W'(mfps_pkg::IN_W - 1)) begin
			r = mfps_pkg::IN_W'(x << (mfps_pkg::MSB_W'(mfps_pkg::IN_W - 1) - msb));
		end else begin
			r = mfps_pkg::IN_W'(x >> (msb - mfps_pkg::MSB_W'(mfps_pkg::IN_W - 1)));
		end
		return r;
	endfunction

	function automatic mfps_pkg::div_t div_init(logic [mfps_pkg::DIV_W-1:0] num,
		logic [mfps_pkg::DIV_W-1:0] den);
		mfps_pkg::div_t d;
		d.rem = num << mfps_pkg::FRAC_BITS;
		d.den = den;
		d.quo = '0;
		d.ovf = (d.rem >= (den << mfps_pkg::DIV_QB));
		return d;
	endfunction

	function automatic mfps_pkg::div_t div_step(mfps_pkg::div_t d, int unsigned b);
		mfps_pkg::div_t r;
		logic [mfps_pkg::DIV_W-1:0] sh;
		r  = d;
		sh = d.den << b;
		if (d.rem >= sh) begin
			r.rem = d.rem - sh;
			r.quo = d.quo | (mfps_pkg::DIV_QB'(1) << b);
		end
		return r;
	endfunction

	function automatic logic [mfps_pkg::FL_W-1:0] q_lim(mfps_pkg::div_t d,
		logic [mfps_pkg::FL_W-1:0] cap);
		logic [mfps_pkg::FL_W-1:0] r;
		if (d.ovf || (d.quo > cap)) r = cap;
		else r = d.quo;
		return r;
	endfunction

	// configuration registers
	logic [mfps_pkg::E_W-1:0]   err_q;
	logic [mfps_pkg::DB_W-1:0]  db_len_q;
	logic [mfps_pkg::EXT_W-1:0] qext_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q    <= '0;
			db_len_q <= '0;
			qext_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mfps_pkg::CFG_ERR:   err_q    <= cfg_data[mfps_pkg::E_W-1:0];
				mfps_pkg::CFG_DBLEN: db_len_q <= cfg_data[mfps_pkg::DB_W-1:0];
				mfps_pkg::CFG_QEXT:  qext_q   <= cfg_data[mfps_pkg::EXT_W-1:0];
				default: ;
			endcase
		end
	end

	// shared stage enable, held only when the output queue is full
	logic                      en;
	logic [mfps_pkg::NST-1:0]  vld_q;
	logic [1:0]                cnt_q;

	assign en       = (cnt_q != 2'(mfps_pkg::OQ_DEPTH));
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[mfps_pkg::NST-2:0], in_valid};
		end
	end

	// stage 1: extended span, signed
	mfps_pkg::s1_t             in_s1;
	logic signed [mfps_pkg::IN_W+1:0] span_c;

	assign span_c = $signed({2'b00, span_end})
		+ $signed({{(mfps_pkg::IN_W + 2 - mfps_pkg::EXT_W){1'b0}}, qext_q})
		- $signed({2'b00, span_start});

	always_ff @(posedge clk) begin
		if (en) begin
			in_s1.cov  <= covered_count;
			in_s1.dev  <= spread_q8;
			in_s1.len  <= read_len;
			in_s1.span <= span_c;
		end
	end

	// stage 2: divider operands, special case flags, log2 normalization
	mfps_pkg::mid_t mid_s [mfps_pkg::LOG_STEPS+1];
	mfps_pkg::mid_t s2_d;
	logic [mfps_pkg::QS_W-1:0]        span_pos;
	logic [mfps_pkg::E_W-1:0]         e_comp;
	logic [mfps_pkg::E_W+mfps_pkg::IN_W-1:0] el_prod;
	logic [mfps_pkg::MSB_W-1:0]       msb_l;
	logic [mfps_pkg::MSB_W-1:0]       msb_d;

	always_comb begin
		span_pos = in_s1.span[mfps_pkg::QS_W-1:0];
		// wraps above an error rate of one, where the coverage divide is bypassed
		e_comp   = mfps_pkg::E_ONE - err_q;
		el_prod  = (mfps_pkg::E_W + mfps_pkg::IN_W)'(err_q)
			* (mfps_pkg::E_W + mfps_pkg::IN_W)'(in_s1.len);
		msb_l    = msb_pos(mfps_pkg::DB_W'(in_s1.len));
		msb_d    = msb_pos(db_len_q);

		s2_d.op.sp_num = mfps_pkg::SPN_W'(in_s1.dev) * mfps_pkg::SPN_W'(mfps_pkg::SQRT2_Q20);
		s2_d.op.sp_den = {el_prod, 12'b0};
		s2_d.op.qs_num = span_pos;
		s2_d.op.qs_den = in_s1.len;
		s2_d.op.cv_num = {in_s1.cov, 16'b0};
		s2_d.op.cv_den = mfps_pkg::CVD_W'(span_pos) * mfps_pkg::CVD_W'(e_comp);

		s2_d.lg.ml = norm(mfps_pkg::DB_W'(in_s1.len), msb_l);
		s2_d.lg.md = norm(db_len_q, msb_d);
		s2_d.lg.rl = mfps_pkg::LR_W'(msb_l) << mfps_pkg::LOG_FRAC;
		s2_d.lg.rd = mfps_pkg::LR_W'(msb_d) << mfps_pkg::LOG_FRAC;

		s2_d.fl.len_zero  = (in_s1.len == '0);
		s2_d.fl.e_zero    = (err_q == '0);
		s2_d.fl.e_ge1     = (err_q >= mfps_pkg::E_ONE);
		s2_d.fl.span_zero = (in_s1.span == '0);
		s2_d.fl.span_neg  = in_s1.span[mfps_pkg::IN_W+1];
		s2_d.fl.db_zero   = (db_len_q == '0);
		s2_d.fl.db_one    = (db_len_q == mfps_pkg::DB_W'(1));
	end

	always_ff @(posedge clk) begin
		if (en) mid_s[0] <= s2_d;
	end

	// log2 of read length and database length: one fraction bit per stage
	for (genvar j = 0; j < mfps_pkg::LOG_STEPS; j++) begin : g_log
		localparam int BI = mfps_pkg::LOG_FRAC - 1 - j;
		mfps_pkg::mid_t nxt;
		logic [2*mfps_pkg::IN_W-1:0] sql;
		logic [2*mfps_pkg::IN_W-1:0] sqd;
		logic [mfps_pkg::IN_W:0]     tl;
		logic [mfps_pkg::IN_W:0]     td;

		always_comb begin
			nxt = mid_s[j];
			sql = mid_s[j].lg.ml * mid_s[j].lg.ml;
			sqd = mid_s[j].lg.md * mid_s[j].lg.md;
			tl  = sql[2*mfps_pkg::IN_W-1:mfps_pkg::IN_W-1];
			td  = sqd[2*mfps_pkg::IN_W-1:mfps_pkg::IN_W-1];
			if (tl[mfps_pkg::IN_W]) begin
				nxt.lg.ml     = tl[mfps_pkg::IN_W:1];
				nxt.lg.rl[BI] = 1'b1;
			end else begin
				nxt.lg.ml = tl[mfps_pkg::IN_W-1:0];
			end
			if (td[mfps_pkg::IN_W]) begin
				nxt.lg.md     = td[mfps_pkg::IN_W:1];
				nxt.lg.rd[BI] = 1'b1;
			end else begin
				nxt.lg.md = td[mfps_pkg::IN_W-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en) mid_s[j+1] <= nxt;
		end
	end

	// divider setup: shifted dividends and overflow check for all four ratios
	mfps_pkg::dvs_t dv_s [mfps_pkg::DIV_QB+1];
	mfps_pkg::dvs_t dvp_d;
	mfps_pkg::mid_t lg_out;

	always_comb begin
		lg_out   = mid_s[mfps_pkg::LOG_STEPS];
		dvp_d.sp = div_init(mfps_pkg::DIV_W'(lg_out.op.sp_num), mfps_pkg::DIV_W'(lg_out.op.sp_den));
		dvp_d.qs = div_init(mfps_pkg::DIV_W'(lg_out.op.qs_num), mfps_pkg::DIV_W'(lg_out.op.qs_den));
		dvp_d.cv = div_init(mfps_pkg::DIV_W'(lg_out.op.cv_num), mfps_pkg::DIV_W'(lg_out.op.cv_den));
		dvp_d.ln = div_init(mfps_pkg::DIV_W'(lg_out.lg.rl), mfps_pkg::DIV_W'(lg_out.lg.rd));
		dvp_d.fl = lg_out.fl;
	end

	always_ff @(posedge clk) begin
		if (en) dv_s[0] <= dvp_d;
	end

	// restoring division, one quotient bit per stage, msb first
	for (genvar k = 0; k < mfps_pkg::DIV_QB; k++) begin : g_div
		localparam int unsigned QBIT = mfps_pkg::DIV_QB - 1 - k;
		mfps_pkg::dvs_t nxt;

		always_comb begin
			nxt    = dv_s[k];
			nxt.sp = div_step(dv_s[k].sp, QBIT);
			nxt.qs = div_step(dv_s[k].qs, QBIT);
			nxt.cv = div_step(dv_s[k].cv, QBIT);
			nxt.ln = div_step(dv_s[k].ln, QBIT);
		end

		always_ff @(posedge clk) begin
			if (en) dv_s[k+1] <= nxt;
		end
	end

	// factors with their fallbacks, then the two score multiplies
	mfps_pkg::fac_t fac_s [3];
	mfps_pkg::fac_t fin_d;
	mfps_pkg::fac_t sc1_d;
	mfps_pkg::fac_t sc2_d;
	mfps_pkg::dvs_t dv_out;
	logic [2*mfps_pkg::F_W-1:0] m1;
	logic [2*mfps_pkg::F_W-1:0] m2;

	always_comb begin
		dv_out = dv_s[mfps_pkg::DIV_QB];

		// zero error rate or zero length: no deviation penalty
		if (dv_out.fl.e_zero || dv_out.fl.len_zero) fin_d.fs = mfps_pkg::ONE;
		else fin_d.fs = mfps_pkg::ONE
			- mfps_pkg::F_W'(q_lim(dv_out.sp, mfps_pkg::FL_W'(mfps_pkg::ONE)));

		if (dv_out.fl.len_zero) fin_d.fp = mfps_pkg::ONE;
		else if (dv_out.fl.span_neg || dv_out.fl.span_zero) fin_d.fp = '0;
		else fin_d.fp = mfps_pkg::F_W'(q_lim(dv_out.qs, mfps_pkg::FL_W'(mfps_pkg::ONE)));

		if (dv_out.fl.span_zero || dv_out.fl.e_ge1) fin_d.fc = mfps_pkg::ONE;
		else if (dv_out.fl.span_neg) fin_d.fc = '0;
		else fin_d.fc = mfps_pkg::F_W'(q_lim(dv_out.cv, mfps_pkg::FL_W'(mfps_pkg::ONE)));

		// database of one base has a zero log, so the ratio saturates
		if (dv_out.fl.len_zero || dv_out.fl.db_zero) fin_d.fl = '0;
		else if (dv_out.fl.db_one) fin_d.fl = mfps_pkg::LEN_CAP;
		else fin_d.fl = q_lim(dv_out.ln, mfps_pkg::LEN_CAP);

		fin_d.p = '0;

		m1      = fac_s[0].fs * fac_s[0].fp;
		sc1_d   = fac_s[0];
		sc1_d.p = m1[mfps_pkg::FRAC_BITS +: mfps_pkg::F_W];

		m2      = fac_s[1].p * fac_s[1].fc;
		sc2_d   = fac_s[1];
		sc2_d.p = m2[mfps_pkg::FRAC_BITS +: mfps_pkg::F_W];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fac_s[0] <= fin_d;
			fac_s[1] <= sc1_d;
			fac_s[2] <= sc2_d;
		end
	end

	// last multiply by the length factor, clamp to one, into the output queue
	mfps_pkg::fac_t sc3_d;
	logic [mfps_pkg::F_W+mfps_pkg::FL_W-1:0] m3;
	logic [mfps_pkg::F_W+1:0]               t3;

	always_comb begin
		m3    = (mfps_pkg::F_W + mfps_pkg::FL_W)'(fac_s[2].p)
			* (mfps_pkg::F_W + mfps_pkg::FL_W)'(fac_s[2].fl);
		t3    = m3[mfps_pkg::FRAC_BITS +: mfps_pkg::F_W + 2];
		sc3_d = fac_s[2];
		if (t3 > (mfps_pkg::F_W + 2)'(mfps_pkg::ONE)) sc3_d.p = mfps_pkg::ONE;
		else sc3_d.p = t3[mfps_pkg::F_W-1:0];
	end

	// output queue: head at entry 0, push lands behind any waiting result
	mfps_pkg::fac_t oq_q [mfps_pkg::OQ_DEPTH];
	logic           push;
	logic           pop;
	logic           wr_idx;

	assign push   = en && vld_q[mfps_pkg::NST-1];
	assign pop    = out_valid && out_ready;
	assign wr_idx = 1'(cnt_q - {1'b0, pop});

	always_ff @(posedge clk) begin
		// a push into the head slot wins over the shift
		if (push && !wr_idx) oq_q[0] <= sc3_d;
		else if (pop) oq_q[0] <= oq_q[1];
		if (push && wr_idx) oq_q[1] <= sc3_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
		end
	end

	assign out_valid       = (cnt_q != '0);
	assign score_q15       = oq_q[0].p;
	assign spread_factor   = oq_q[0].fs;
	assign span_factor     = oq_q[0].fp;
	assign coverage_factor = oq_q[0].fc;
	assign length_factor   = oq_q[0].fl;

endmodule

FILE: rtl/core/mfps_checker.sv
// mfps_checker: port-level assertions for the mapping false-positive scorer
// depends on mfps_pkg; bound to mapping_false_positive_score at the end of this file
module mfps_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [mfps_pkg::F_W-1:0]          score_q15,
	input logic [mfps_pkg::F_W-1:0]          spread_factor,
	input logic [mfps_pkg::F_W-1:0]          span_factor,
	input logic [mfps_pkg::F_W-1:0]          coverage_factor,
	input logic [mfps_pkg::FL_W-1:0]         length_factor
);

	// a result held back by the receiver stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(score_q15)
			&& $stable(spread_factor) && $stable(span_factor)
			&& $stable(coverage_factor) && $stable(length_factor))
		else $error("result changed while stalled");

	// score and the unit factors never exceed one
	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> score_q15 <= mfps_pkg::ONE && spread_factor <= mfps_pkg::ONE
			&& span_factor <= mfps_pkg::ONE && coverage_factor <= mfps_pkg::ONE)
		else $error("factor above one");

	// with a length factor of at most one the product cannot grow past any factor
	a_product: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && length_factor <= mfps_pkg::FL_W'(mfps_pkg::ONE)
			|-> score_q15 <= spread_factor && score_q15 <= span_factor
			&& score_q15 <= coverage_factor)
		else $error("score exceeds a factor");

	// a dead span kills the score
	a_zero_span: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (span_factor == '0 || coverage_factor == '0) |-> score_q15 == '0)
		else $error("nonzero score with a zero factor");

endmodule

bind mapping_false_positive_score mfps_checker u_mfps_checker (.*);
